// ===== hdl/tfd_pkg.sv =====
// Shared constants and types for the touch frame decoder.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package tfd_pkg;

    // Screen geometry.
    localparam int SCREEN_W = 800;
    localparam int SCREEN_H = 600;
    localparam int SIZE_MAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int SIZE_W   = $clog2(SIZE_MAX + 1);

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int CAL_W      = 16;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Calibration arithmetic.
    localparam int RAW_LIMIT = 1000;
    localparam int RAW_W     = $clog2(RAW_LIMIT);
    localparam int X_OFFSET  = 4;
    localparam int Y_OFFSET  = 6;
    localparam int OFF_W     = 3;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = CAL_W + SIZE_W;
    localparam int DIVD_W    = PROD_W + FRAC_W;
    localparam int V_W       = DIVD_W + 2;
    localparam int CNT_W     = $clog2(DIVD_W);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEN_DOWN_CODE = 3'd0,
        REG_PEN_UP_CODE   = 3'd1,
        REG_CAL_LEFT_X    = 3'd2,
        REG_CAL_LEFT_Y    = 3'd3,
        REG_CAL_RIGHT_X   = 3'd4,
        REG_CAL_RIGHT_Y   = 3'd5,
        REG_TIMEOUT_TICKS = 3'd6
    } reg_idx_t;

    // Input mode and event codes.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam logic EV_DOWN   = 1'b0;
    localparam logic EV_UP     = 1'b1;

endpackage

// ===== hdl/tfd_in_if.sv =====
// Request channel of the touch frame decoder: a serial byte or a timer tick.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

interface tfd_in_if;
    import tfd_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// ===== hdl/tfd_out_if.sv =====
// Event channel of the touch frame decoder: pen event and screen position.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

interface tfd_out_if;
    import tfd_pkg::*;

    logic             valid;
    logic             ready;
    logic             event_res;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;

    modport source (output valid, output event_res, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input event_res, input pos_x, input pos_y, output ready);
endinterface

// ===== hdl/touch_frame_decoder.sv =====
// Touch-panel serial frame decoder with two-point calibration and pen-up timeout.
// Depends on tfd_pkg, tfd_in_if and tfd_out_if.
`timescale 1ns / 1ps

//  channel  | direction | payload                      | request taken when
//  ---------+-----------+------------------------------+----------------------
//  req      | in        | mode, rx_byte                | req.valid & req.ready
//  rsp      | out       | event_res, pos_x, pos_y      | rsp.valid & rsp.ready
//  cfg_*    | in        | cfg_index, cfg_data          | cfg_we
//
// A tick that raises no event, or a byte that does not end a frame, leaves the block
// ready for the next request. A frame's last byte with both raw readings in range runs
// the calibration on each axis in turn: a multiply step, a restoring divider that
// yields the DIVD_W-bit quotient (42 bits at the default screen size) one bit per
// cycle, and a saturate step; an axis with a zero calibration span skips the divider.
// A request that raises an event then passes through the emit state, which loads the
// output register. Reset clears the control state and loads the configuration defaults.
// A result waiting in the output register does not stop new requests; only a second
// event meeting a still-full output register holds the block until the first is taken.

module touch_frame_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    tfd_in_if.sink                         req,
    tfd_out_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tfd_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIX  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [BYTE_W-1:0] down_code_reg, up_code_reg, timeout_reg;
    logic [CAL_W-1:0]  left_x_reg, left_y_reg, right_x_reg, right_y_reg;

    // Decoder state.
    logic              pen_down_reg, pen_down_next;
    logic [BYTE_W-1:0] tick_reg, tick_next;
    logic [2:0]        fpos_reg, fpos_next;
    logic              fdown_reg, fdown_next;
    logic [BYTE_W-1:0] fbyte_reg [3];
    logic [BYTE_W-1:0] fbyte_next [3];
    logic [POS_W-1:0]  xpos_reg, xpos_next, ypos_reg, ypos_next;

    // Calibration working registers.
    logic [RAW_W-1:0]  raw_x_reg, raw_x_next, raw_y_reg, raw_y_next;
    logic              axis_reg, axis_next;
    logic              neg_reg, neg_next;
    logic [CAL_W-1:0]  dmag_reg, dmag_next;
    logic [CAL_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ev_pend_reg, ev_pend_next;
    logic              ev_code_reg, ev_code_next;

    // Output register.
    logic              ov_reg, ov_next;
    logic              oev_reg, oev_next;
    logic [POS_W-1:0]  ox_reg, ox_next, oy_reg, oy_next;

    // Per-axis operand selection for the shared unit.
    logic [RAW_W-1:0]         sel_raw;
    logic [CAL_W-1:0]         sel_left, sel_right;
    logic [SIZE_W-1:0]        sel_size;
    logic [OFF_W-1:0]         sel_off;
    logic signed [CAL_W:0]    diff_s, den_s;
    logic [CAL_W-1:0]         diff_mag, den_mag;
    logic [PROD_W-1:0]        prod;
    logic [CAL_W:0]           rem_sh, rem_sub;
    logic                     fits;
    logic signed [V_W-1:0]    k_s, q_s, v_s;
    logic [POS_W-1:0]         pos_sat;
    logic [2*BYTE_W-1:0]      raw_x_full, raw_y_full;
    logic                     raw_ok;

    assign sel_raw   = axis_reg ? raw_y_reg : raw_x_reg;
    assign sel_left  = axis_reg ? left_y_reg : left_x_reg;
    assign sel_right = axis_reg ? right_y_reg : right_x_reg;
    assign sel_size  = axis_reg ? SIZE_W'(SCREEN_H) : SIZE_W'(SCREEN_W);
    assign sel_off   = axis_reg ? OFF_W'(Y_OFFSET) : OFF_W'(X_OFFSET);

    assign diff_s   = $signed({{(CAL_W + 1 - RAW_W){1'b0}}, sel_raw})
                    - $signed({1'b0, sel_right});
    assign den_s    = $signed({1'b0, sel_left}) - $signed({1'b0, sel_right});
    // Both differences stay within the magnitude of a calibration reading.
    assign diff_mag = diff_s[CAL_W] ? CAL_W'(-diff_s) : CAL_W'(diff_s);
    assign den_mag  = den_s[CAL_W] ? CAL_W'(-den_s) : CAL_W'(den_s);
    assign prod     = PROD_W'(diff_mag) * PROD_W'(sel_size);

    // One restoring division step.
    assign rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits    = rem_sh >= {1'b0, dmag_reg};
    assign rem_sub = rem_sh - {1'b0, dmag_reg};

    // Position = (SIZE + OFF) - signed quotient, taken in 16.16 and saturated.
    assign k_s = $signed((V_W'(sel_size) + V_W'(sel_off)) << FRAC_W);
    assign q_s = $signed(V_W'(quo_reg));
    assign v_s = neg_reg ? (k_s + q_s) : (k_s - q_s);

    always_comb
    begin
        if (v_s[V_W-1])
            pos_sat = '0;
        else if (|v_s[V_W-2:FRAC_W+POS_W])
            pos_sat = '1;
        else
            pos_sat = v_s[FRAC_W+POS_W-1:FRAC_W];
    end

    // Raw readings of a completed frame; the current byte is the last one.
    always_comb
    begin
        if (fdown_reg)
        begin
            raw_x_full = (2*BYTE_W)'({fbyte_reg[0], 7'd0}) + (2*BYTE_W)'(fbyte_reg[1]);
            raw_y_full = (2*BYTE_W)'({fbyte_reg[2], 7'd0}) + (2*BYTE_W)'(req.rx_byte);
        end
        else
        begin
            raw_x_full = (2*BYTE_W)'({fbyte_reg[1], 7'd0}) + (2*BYTE_W)'(fbyte_reg[0]);
            raw_y_full = (2*BYTE_W)'({req.rx_byte, 7'd0}) + (2*BYTE_W)'(fbyte_reg[2]);
        end
    end

    assign raw_ok = (raw_x_full < (2*BYTE_W)'(RAW_LIMIT))
                 && (raw_y_full < (2*BYTE_W)'(RAW_LIMIT));

    assign req.ready = (state_reg == S_IDLE);

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        pen_down_next = pen_down_reg;
        tick_next     = tick_reg;
        fpos_next     = fpos_reg;
        fdown_next    = fdown_reg;
        fbyte_next    = fbyte_reg;
        xpos_next     = xpos_reg;
        ypos_next     = ypos_reg;
        raw_x_next    = raw_x_reg;
        raw_y_next    = raw_y_reg;
        axis_next     = axis_reg;
        neg_next      = neg_reg;
        dmag_next     = dmag_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        ev_pend_next  = ev_pend_reg;
        ev_code_next  = ev_code_reg;
        ov_next       = ov_reg;
        oev_next      = oev_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;

        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.mode == MODE_TICK)
                    begin
                        tick_next = tick_reg + BYTE_W'(1);
                        if (tick_reg > timeout_reg)
                        begin
                            pen_down_next = 1'b0;
                            tick_next     = '0;
                            if (pen_down_reg)
                            begin
                                ev_code_next = EV_UP;
                                state_next   = S_EMIT;
                            end
                        end
                    end
                    else
                    begin
                        unique case (fpos_reg)
                            3'd0:
                            begin
                                if (req.rx_byte == down_code_reg)
                                begin
                                    fdown_next = 1'b1;
                                    fpos_next  = 3'd1;
                                end
                                else if (req.rx_byte == up_code_reg)
                                begin
                                    fdown_next = 1'b0;
                                    fpos_next  = 3'd1;
                                end
                            end
                            3'd1, 3'd2, 3'd3:
                            begin
                                fbyte_next[fpos_reg[1:0] - 2'd1] = req.rx_byte;
                                fpos_next = fpos_reg + 3'd1;
                            end
                            default:
                            begin
                                // Fourth data byte: the frame is complete.
                                fpos_next     = '0;
                                tick_next     = '0;
                                pen_down_next = fdown_reg;
                                ev_pend_next  = (fdown_reg != pen_down_reg);
                                ev_code_next  = fdown_reg ? EV_DOWN : EV_UP;
                                if (raw_ok)
                                begin
                                    raw_x_next = raw_x_full[RAW_W-1:0];
                                    raw_y_next = raw_y_full[RAW_W-1:0];
                                    axis_next  = 1'b0;
                                    state_next = S_MUL;
                                end
                                else if (fdown_reg != pen_down_reg)
                                    state_next = S_EMIT;
                            end
                        endcase
                    end
                end
            end

            S_MUL:
            begin
                if (den_s == '0)
                begin
                    // Degenerate calibration: this axis keeps its old position.
                    if (!axis_reg)
                        axis_next = 1'b1;
                    else
                        state_next = ev_pend_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    quo_next   = {prod, {FRAC_W{1'b0}}};
                    rem_next   = '0;
                    neg_next   = diff_s[CAL_W] ^ den_s[CAL_W];
                    dmag_next  = den_mag;
                    cnt_next   = CNT_W'(DIVD_W - 1);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = fits ? rem_sub[CAL_W-1:0] : rem_sh[CAL_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], fits};
                if (cnt_reg == '0)
                    state_next = S_FIX;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end

            S_FIX:
            begin
                if (!axis_reg)
                begin
                    xpos_next  = pos_sat;
                    axis_next  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    ypos_next  = pos_sat;
                    state_next = ev_pend_reg ? S_EMIT : S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next      = 1'b1;
                    oev_next     = ev_code_reg;
                    ox_next      = xpos_reg;
                    oy_next      = ypos_reg;
                    ev_pend_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state and positions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pen_down_reg <= 1'b0;
            tick_reg     <= '0;
            fpos_reg     <= '0;
            fdown_reg    <= 1'b0;
            xpos_reg     <= '0;
            ypos_reg     <= '0;
            axis_reg     <= 1'b0;
            cnt_reg      <= '0;
            ev_pend_reg  <= 1'b0;
            ev_code_reg  <= EV_DOWN;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pen_down_reg <= pen_down_next;
            tick_reg     <= tick_next;
            fpos_reg     <= fpos_next;
            fdown_reg    <= fdown_next;
            xpos_reg     <= xpos_next;
            ypos_reg     <= ypos_next;
            axis_reg     <= axis_next;
            cnt_reg      <= cnt_next;
            ev_pend_reg  <= ev_pend_next;
            ev_code_reg  <= ev_code_next;
            ov_reg       <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fbyte_reg <= fbyte_next;
        raw_x_reg <= raw_x_next;
        raw_y_reg <= raw_y_next;
        neg_reg   <= neg_next;
        dmag_reg  <= dmag_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        oev_reg   <= oev_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
    end

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_code_reg <= 8'd128;
            up_code_reg   <= 8'd129;
            left_x_reg    <= '0;
            left_y_reg    <= '0;
            right_x_reg   <= '0;
            right_y_reg   <= '0;
            timeout_reg   <= 8'd100;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PEN_DOWN_CODE: down_code_reg <= cfg_data[BYTE_W-1:0];
                REG_PEN_UP_CODE:   up_code_reg   <= cfg_data[BYTE_W-1:0];
                REG_CAL_LEFT_X:    left_x_reg    <= cfg_data[CAL_W-1:0];
                REG_CAL_LEFT_Y:    left_y_reg    <= cfg_data[CAL_W-1:0];
                REG_CAL_RIGHT_X:   right_x_reg   <= cfg_data[CAL_W-1:0];
                REG_CAL_RIGHT_Y:   right_y_reg   <= cfg_data[CAL_W-1:0];
                REG_TIMEOUT_TICKS: timeout_reg   <= cfg_data[BYTE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign rsp.valid     = ov_reg;
    assign rsp.event_res = oev_reg;
    assign rsp.pos_x     = ox_reg;
    assign rsp.pos_y     = oy_reg;

    // The frame position never passes the last data byte.
    assert property (@(posedge clk) disable iff (!rst_n) fpos_reg <= 3'd4)
        else $error("frame position out of range");

    // The divider only runs with a non-zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dmag_reg != '0))
        else $error("division started with a zero divisor");

    // The last division step is followed by the saturate step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_FIX))
        else $error("divider did not hand over to the saturate step");

    // A new result appears only from the emit state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_EMIT))
        else $error("result loaded outside the emit state");

endmodule
